// File: rtl/l2m_pkg.sv
// shared types and constants for the latitude to mercator v pipeline
package l2m_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 20;
	localparam int V_FRAC_BITS_DEF     = 30;

	localparam int LAT_W    = 28;
	localparam int LIM_W    = 27;
	localparam int OUT_W    = 31;
	localparam int LOG_BITS = 56;
	localparam int REM_W    = 10;
	localparam int CHUNK_W  = 16;

	localparam logic [LIM_W-1:0] LAT_LIMIT_RST = 27'd89182573;

	localparam logic [63:0]  Q62_ONE  = 64'h4000_0000_0000_0000;
	localparam logic [63:0]  PIQ62    = 64'hC90F_DAA2_2168_C234;
	localparam logic [63:0]  LN2Q64   = 64'hB172_17F7_D1CF_79AB;
	localparam logic [63:0]  TWOPIQ64 = 64'hA2F9_836E_4E44_1529;
	// pi/180 in q64
	localparam logic [63:0]  DEG_Q64  = PIQ62 / 64'd45;
	localparam logic [127:0] K_PROD   = {64'd0, LN2Q64} * {64'd0, TWOPIQ64};
	// ln2/(4 pi) in q67
	localparam logic [63:0]  K_Q67    = K_PROD[127:64];

	typedef enum logic [1:0] {
		K_CALC  = 2'd0,
		K_NORTH = 2'd1,
		K_SOUTH = 2'd2,
		K_FULL  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  neg;
	} ctl_t;

endpackage

// File: rtl/l2m_mul.sv
// 64x64 multiplier, four 32x32 partial products then a 128-bit sum
module l2m_mul import l2m_pkg::*; #(
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vin,
	input  logic [63:0]   a,
	input  logic [63:0]   b,
	input  logic [PW-1:0] pin,
	output logic          vout,
	output logic [127:0]  p,
	output logic [PW-1:0] pout
);

	logic          v_s1, v_s2;
	logic [63:0]   ll_s1, lh_s1, hl_s1, hh_s1;
	logic [PW-1:0] pay_s1, pay_s2;
	logic [127:0]  p_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1  <= 64'(a[31:0])  * 64'(b[31:0]);
			lh_s1  <= 64'(a[31:0])  * 64'(b[63:32]);
			hl_s1  <= 64'(a[63:32]) * 64'(b[31:0]);
			hh_s1  <= 64'(a[63:32]) * 64'(b[63:32]);
			pay_s1 <= pin;
			p_s2   <= {hh_s1, 64'd0} + ({64'd0, lh_s1} << 32) + ({64'd0, hl_s1} << 32)
				+ {64'd0, ll_s1};
			pay_s2 <= pay_s1;
		end
	end

	assign vout = v_s2;
	assign p    = p_s2;
	assign pout = pay_s2;

endmodule

// File: rtl/l2m_cdiv.sv
// divide a 64-bit value by a small constant, one 16-bit digit per stage
module l2m_cdiv import l2m_pkg::*; #(
	parameter int DIV = 6,
	parameter int PW  = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vin,
	input  logic [63:0]   num,
	input  logic [PW-1:0] pin,
	output logic          vout,
	output logic [63:0]   quo,
	output logic [PW-1:0] pout
);

	localparam int XW = REM_W + CHUNK_W;
	localparam logic [33:0] MAGIC = 34'((64'd1 << 36) / DIV);

	logic [4:1]       v_s;
	logic [63:0]      num_s [1:3];
	logic [63:0]      quo_s [1:4];
	logic [REM_W-1:0] rem_s [1:4];
	logic [PW-1:0]    pay_s [1:4];

	for (genvar j = 1; j <= 4; j++) begin : g_dig
		logic             sv;
		logic [63:0]      snum, squo, nq;
		logic [REM_W-1:0] srem;
		logic [PW-1:0]    spay;
		logic [XW-1:0]    x, r0, rn;
		logic [59:0]      prod;
		logic [15:0]      q0, qc;
		logic             fix;

		if (j == 1) begin : g_first
			assign sv   = vin;
			assign snum = num;
			assign squo = '0;
			assign srem = '0;
			assign spay = pin;
		end else begin : g_next
			assign sv   = v_s[j-1];
			assign snum = num_s[j-1];
			assign squo = quo_s[j-1];
			assign srem = rem_s[j-1];
			assign spay = pay_s[j-1];
		end

		// reciprocal estimate is low by at most one
		always_comb begin
			x    = {srem, snum[63-16*(j-1) -: 16]};
			prod = 60'(x) * 60'(MAGIC);
			q0   = prod[51:36];
			r0   = x - XW'(32'(q0) * DIV);
			fix  = (r0 >= XW'(DIV));
			qc   = q0 + 16'(fix);
			rn   = fix ? (r0 - XW'(DIV)) : r0;
			nq   = squo;
			nq[63-16*(j-1) -: 16] = qc;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= sv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[j] <= nq;
				rem_s[j] <= REM_W'(rn);
				pay_s[j] <= spay;
			end
		end

		if (j < 4) begin : g_num
			always_ff @(posedge clk) begin
				if (en) begin
					num_s[j] <= snum;
				end
			end
		end
	end

	assign vout = v_s[4];
	assign quo  = quo_s[4];
	assign pout = pay_s[4];

	ap_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[4] |-> (rem_s[4] < REM_W'(DIV)))
		else $error("remainder not below divisor");

endmodule

// File: rtl/l2m_norm.sv
// leading-one search and left normalization to bit 62
module l2m_norm import l2m_pkg::*; #(
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vin,
	input  logic [63:0]   x,
	input  logic [PW-1:0] pin,
	output logic          vout,
	output logic [63:0]   xn,
	output logic [5:0]    e,
	output logic [PW-1:0] pout
);

	logic          v_s1, v_s2, v_s3;
	logic [7:0]    grp_s1;
	logic [63:0]   x_s1, x_s2, xn_s3;
	logic [5:0]    e_s2, e_s3;
	logic [PW-1:0] pay_s1, pay_s2, pay_s3;
	logic [7:0]    grp;
	logic [2:0]    g, bsel;
	logic [7:0]    byt;

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			grp[j] = |x[8*j +: 8];
		end
	end

	always_comb begin
		g    = '0;
		bsel = '0;
		for (int j = 0; j < 8; j++) begin
			if (grp_s1[j]) g = 3'(j);
		end
		byt = x_s1[8*g +: 8];
		for (int j = 0; j < 8; j++) begin
			if (byt[j]) bsel = 3'(j);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grp_s1 <= grp;
			x_s1   <= x;
			pay_s1 <= pin;
			e_s2   <= {g, bsel};
			x_s2   <= x_s1;
			pay_s2 <= pay_s1;
			xn_s3  <= x_s2 << (6'd62 - e_s2);
			e_s3   <= e_s2;
			pay_s3 <= pay_s2;
		end
	end

	assign vout = v_s3;
	assign xn   = xn_s3;
	assign e    = e_s3;
	assign pout = pay_s3;

endmodule

// File: rtl/l2m_logstep.sv
// one log2 fraction bit for both mantissas: square, then renormalize
module l2m_logstep import l2m_pkg::*; #(
	parameter int PW = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vin,
	input  logic [63:0]         mp,
	input  logic [63:0]         mm,
	input  logic [LOG_BITS-1:0] fp,
	input  logic [LOG_BITS-1:0] fm,
	input  logic [PW-1:0]       pin,
	output logic                vout,
	output logic [63:0]         mp_o,
	output logic [63:0]         mm_o,
	output logic [LOG_BITS-1:0] fp_o,
	output logic [LOG_BITS-1:0] fm_o,
	output logic [PW-1:0]       pout
);

	logic                v_s1, v_s2;
	logic [63:0]         pll_s1, plh_s1, phh_s1, mll_s1, mlh_s1, mhh_s1;
	logic [LOG_BITS-1:0] fp_s1, fm_s1, fp_s2, fm_s2;
	logic [PW-1:0]       pay_s1, pay_s2;
	logic [63:0]         mp_s2, mm_s2;
	logic [127:0]        sqp, sqm;
	logic [63:0]         qp, qm;

	always_comb begin
		sqp = {phh_s1, 64'd0} + ({64'd0, plh_s1} << 33) + {64'd0, pll_s1};
		sqm = {mhh_s1, 64'd0} + ({64'd0, mlh_s1} << 33) + {64'd0, mll_s1};
		qp  = sqp[125:62];
		qm  = sqm[125:62];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pll_s1 <= 64'(mp[31:0])  * 64'(mp[31:0]);
			plh_s1 <= 64'(mp[31:0])  * 64'(mp[63:32]);
			phh_s1 <= 64'(mp[63:32]) * 64'(mp[63:32]);
			mll_s1 <= 64'(mm[31:0])  * 64'(mm[31:0]);
			mlh_s1 <= 64'(mm[31:0])  * 64'(mm[63:32]);
			mhh_s1 <= 64'(mm[63:32]) * 64'(mm[63:32]);
			fp_s1  <= fp;
			fm_s1  <= fm;
			pay_s1 <= pin;
			// square reaching two shifts a one into the fraction
			mp_s2  <= qp[63] ? (qp >> 1) : qp;
			mm_s2  <= qm[63] ? (qm >> 1) : qm;
			fp_s2  <= {fp_s1[LOG_BITS-2:0], qp[63]};
			fm_s2  <= {fm_s1[LOG_BITS-2:0], qm[63]};
			pay_s2 <= pay_s1;
		end
	end

	assign vout = v_s2;
	assign mp_o = mp_s2;
	assign mm_o = mm_s2;
	assign fp_o = fp_s2;
	assign fm_o = fm_s2;
	assign pout = pay_s2;

endmodule

// File: rtl/latitude_to_mercator_v.sv
// latitude to normalized web mercator v, fully pipelined
//
// Input channel: latitude (signed, 2^-ANGLE_FRAC_BITS degree) on in_valid/in_ready.
// Output channel: v_coord (1.0 = 2^V_FRAC_BITS) on out_valid/out_ready.
// Config: cfg_we writes cfg_data into the clamp limit; write only while idle.
// Every request gives exactly one result, in order.
// Depth: 199 register stages: 3 front stages, 2 per multiply, 4 per
// series divide, 3 to normalize, 2 per log2 fraction bit over 56 bits,
// 1 result stage. Throughput: one request per cycle while the skid
// register is empty; 12 series terms and 56 log2 bits are each unrolled
// into their own stages.
// Reset clears all valid bits and loads the default limit of about 85.05
// degrees; the pipeline is empty and ready right after reset.
// When the receiver stalls, the last result moves into a skid register and
// the whole pipeline then holds; in_ready drops only while the skid
// register is full, so nothing is lost or repeated.
module latitude_to_mercator_v import l2m_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int V_FRAC_BITS     = V_FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LIM_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [LAT_W-1:0] latitude,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] v_coord
);

	localparam int AW    = ANGLE_FRAC_BITS + 9;
	localparam int NSTEP = (ANGLE_FRAC_BITS >= 19) ? 1 : (20 - ANGLE_FRAC_BITS);
	localparam int WW    = AW + NSTEP;
	localparam int VW    = V_FRAC_BITS + 1;
	localparam int CW    = $bits(ctl_t);
	localparam int PT    = CW + 128;
	localparam int PL    = CW + 6;
	localparam logic [AW-1:0] D360 = AW'(360) << ANGLE_FRAC_BITS;
	localparam logic [AW-1:0] D180 = AW'(180) << ANGLE_FRAC_BITS;
	localparam logic [AW-1:0] D90  = AW'(90) << ANGLE_FRAC_BITS;
	localparam logic [63:0]   RND  = 64'd1 << (58 - V_FRAC_BITS);
	localparam logic [63:0]   HALF = 64'd1 << (V_FRAC_BITS - 1);
	localparam logic [VW-1:0] FULL = VW'(1) << V_FRAC_BITS;

	logic             adv;
	logic [LIM_W-1:0] lat_limit_q;
	logic             res_v_q, sk_v_q;

	// front end
	logic [LAT_W:0]   lat29, lim29;
	logic             north, south;
	kind_t            kind_in;
	logic             v_s1, v_s2, v_s3;
	kind_t            kind_s1, kind_s2;
	logic             sgn_s1, sgn_s2;
	logic [LAT_W-1:0] mag_s1;
	logic [AW-1:0]    rem_s2, a_s3;
	ctl_t             ctl_s3;
	logic [WW-1:0]    racc;
	logic [AW-1:0]    a0, a1, a2;
	logic             neg1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_limit_q <= LAT_LIMIT_RST;
		end else if (cfg_we) begin
			lat_limit_q <= cfg_data;
		end
	end

	assign adv      = !sk_v_q;
	assign in_ready = adv;

	always_comb begin
		lat29 = {latitude[LAT_W-1], latitude};
		lim29 = {1'b0, 1'b0, lat_limit_q};
		north = ($signed(lat29) >= $signed(lim29));
		south = ($signed(lat29) <= -$signed(lim29));
		priority if (north) begin
			kind_in = K_NORTH;
		end else if (south) begin
			kind_in = K_SOUTH;
		end else begin
			kind_in = K_CALC;
		end
	end

	// magnitude mod 360 degrees
	always_comb begin
		racc = WW'(mag_s1);
		for (int j = NSTEP - 1; j >= 0; j--) begin
			if (racc >= (WW'(D360) << j)) racc = racc - (WW'(D360) << j);
		end
	end

	// fold into [0, 90] degrees
	always_comb begin
		a0   = (sgn_s2 && (rem_s2 != '0)) ? (D360 - rem_s2) : rem_s2;
		neg1 = (a0 >= D180);
		a1   = neg1 ? (a0 - D180) : a0;
		a2   = (a1 > D90) ? (D180 - a1) : a1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1     <= kind_in;
			sgn_s1      <= latitude[LAT_W-1];
			mag_s1      <= latitude[LAT_W-1] ? LAT_W'(-latitude) : latitude;
			kind_s2     <= kind_s1;
			sgn_s2      <= sgn_s1;
			rem_s2      <= racc[AW-1:0];
			a_s3        <= a2;
			ctl_s3.kind <= kind_s2;
			ctl_s3.neg  <= neg1;
		end
	end

	// theta = a * pi/180
	logic          v_th;
	logic [127:0]  p_th;
	logic [CW-1:0] pay_th;
	logic [63:0]   theta;

	l2m_mul #(.PW(CW)) u_mul_theta (
		.clk(clk), .arst_n(arst_n), .en(adv), .vin(v_s3),
		.a(64'(a_s3)), .b(DEG_Q64), .pin(ctl_s3),
		.vout(v_th), .p(p_th), .pout(pay_th)
	);

	assign theta = p_th[ANGLE_FRAC_BITS+65 : ANGLE_FRAC_BITS+2];

	logic            v_x2;
	logic [127:0]    p_x2;
	logic [CW+63:0]  pay_x2;

	l2m_mul #(.PW(CW + 64)) u_mul_x2 (
		.clk(clk), .arst_n(arst_n), .en(adv), .vin(v_th),
		.a(theta), .b(theta), .pin({pay_th, theta}),
		.vout(v_x2), .p(p_x2), .pout(pay_x2)
	);

	// sine series, one nested term per multiply and divide
	logic [12:0]   tv;
	logic [63:0]   tr   [0:12];
	logic [PT-1:0] tpay [0:12];

	assign tv[0]   = v_x2;
	assign tr[0]   = Q62_ONE;
	assign tpay[0] = {pay_x2, p_x2[125:62]};

	for (genvar i = 0; i < 12; i++) begin : g_term
		localparam int KK = 12 - i;
		localparam int DV = (2 * KK) * (2 * KK + 1);
		logic          mv;
		logic [127:0]  mp;
		logic [PT-1:0] mpay;
		logic [63:0]   quo;

		l2m_mul #(.PW(PT)) u_mul (
			.clk(clk), .arst_n(arst_n), .en(adv), .vin(tv[i]),
			.a(tpay[i][63:0]), .b(tr[i]), .pin(tpay[i]),
			.vout(mv), .p(mp), .pout(mpay)
		);

		l2m_cdiv #(.DIV(DV), .PW(PT)) u_div (
			.clk(clk), .arst_n(arst_n), .en(adv), .vin(mv),
			.num(mp[125:62]), .pin(mpay),
			.vout(tv[i+1]), .quo(quo), .pout(tpay[i+1])
		);

		assign tr[i+1] = Q62_ONE - quo;
	end

	logic          v_sn;
	logic [127:0]  p_sn;
	logic [CW-1:0] pay_sn;
	logic [63:0]   s_raw, s_c, pval, mval;
	ctl_t          ctl_sn, ctl_pm;

	l2m_mul #(.PW(CW)) u_mul_sin (
		.clk(clk), .arst_n(arst_n), .en(adv), .vin(tv[12]),
		.a(tpay[12][127:64]), .b(tr[12]), .pin(tpay[12][PT-1:128]),
		.vout(v_sn), .p(p_sn), .pout(pay_sn)
	);

	always_comb begin
		ctl_sn = ctl_t'(pay_sn);
		s_raw  = p_sn[125:62];
		s_c    = (s_raw > Q62_ONE) ? Q62_ONE : s_raw;
		pval   = Q62_ONE + s_c;
		mval   = Q62_ONE - s_c;
		ctl_pm = ctl_sn;
		// sine of one: the log term saturates
		if ((ctl_sn.kind == K_CALC) && (mval == '0)) ctl_pm.kind = K_FULL;
	end

	logic          v_nm;
	logic [63:0]   m_nm;
	logic [5:0]    e_nm;
	logic [CW+63:0] pay_nm;

	l2m_norm #(.PW(CW + 64)) u_norm (
		.clk(clk), .arst_n(arst_n), .en(adv), .vin(v_sn),
		.x(mval), .pin({ctl_pm, pval}),
		.vout(v_nm), .xn(m_nm), .e(e_nm), .pout(pay_nm)
	);

	// log2 fraction bits of 1+s and 1-s
	logic [56:0]         lv;
	logic [63:0]         lmp  [0:56];
	logic [63:0]         lmm  [0:56];
	logic [LOG_BITS-1:0] lfp  [0:56];
	logic [LOG_BITS-1:0] lfm  [0:56];
	logic [PL-1:0]       lpay [0:56];

	assign lv[0]   = v_nm;
	assign lmp[0]  = pay_nm[63:0];
	assign lmm[0]  = m_nm;
	assign lfp[0]  = '0;
	assign lfm[0]  = '0;
	assign lpay[0] = {pay_nm[CW+63:64], e_nm};

	for (genvar i = 0; i < LOG_BITS; i++) begin : g_log
		l2m_logstep #(.PW(PL)) u_step (
			.clk(clk), .arst_n(arst_n), .en(adv), .vin(lv[i]),
			.mp(lmp[i]), .mm(lmm[i]), .fp(lfp[i]), .fm(lfm[i]), .pin(lpay[i]),
			.vout(lv[i+1]), .mp_o(lmp[i+1]), .mm_o(lmm[i+1]),
			.fp_o(lfp[i+1]), .fm_o(lfm[i+1]), .pout(lpay[i+1])
		);
	end

	// log2 ratio, exponent of 1+s taken as 62 here
	logic [63:0] dval;

	assign dval = (64'(6'd62 - lpay[LOG_BITS][5:0]) << LOG_BITS)
		+ 64'(lfp[LOG_BITS]) - 64'(lfm[LOG_BITS]);

	logic          v_k;
	logic [127:0]  p_k;
	logic [CW-1:0] pay_k;

	l2m_mul #(.PW(CW)) u_mul_k (
		.clk(clk), .arst_n(arst_n), .en(adv), .vin(lv[LOG_BITS]),
		.a(dval), .b(K_Q67), .pin(lpay[LOG_BITS][PL-1:6]),
		.vout(v_k), .p(p_k), .pout(pay_k)
	);

	ctl_t          ctl_k;
	logic [63:0]   rq, rs;
	logic [VW-1:0] vv;

	always_comb begin
		ctl_k = ctl_t'(pay_k);
		rq    = (p_k[127:64] + RND) >> (59 - V_FRAC_BITS);
		rs    = ((ctl_k.kind == K_FULL) || (rq > HALF)) ? HALF : rq;
		unique case (ctl_k.kind)
			K_NORTH: vv = '0;
			K_SOUTH: vv = FULL;
			K_CALC, K_FULL: begin
				vv = ctl_k.neg ? VW'(HALF + rs) : VW'(HALF - rs);
			end
		endcase
	end

	// result register and skid
	logic [OUT_W-1:0] res_q, sk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else begin
			if (adv) res_v_q <= v_k;
			if (sk_v_q) begin
				if (out_ready) sk_v_q <= 1'b0;
			end else if (res_v_q && !out_ready) begin
				sk_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_q <= OUT_W'(vv);
		if (!sk_v_q && res_v_q && !out_ready) sk_q <= res_q;
	end

	assign out_valid = sk_v_q | res_v_q;
	assign v_coord   = sk_v_q ? sk_q : res_q;

	ap_skid_stall: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> !in_ready)
		else $error("request taken while skid register full");

	ap_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_v_q) |-> $past(res_v_q && !out_ready))
		else $error("skid register filled without a stalled result");

	ap_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(sk_v_q && !out_ready) |=> (sk_v_q && $stable(sk_q)))
		else $error("stalled skid result changed");

endmodule
